// ===== rtl/lmcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcd_pkg
// Shared types and constants of the local maximum cross detector: the
// configuration register map and the result record.
// ----------------------------------------------------------------------------
package lmcd_pkg;

	// Configuration port layout
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 11;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

	// Register reset values and the smallest usable frame side
	localparam logic [CFG_DATA_BITS-1:0] FRAME_WIDTH_RESET  = 11'd5;
	localparam logic [CFG_DATA_BITS-1:0] FRAME_HEIGHT_RESET = 11'd5;
	localparam int DIM_MIN = 3;

	// Result queue geometry
	localparam int RES_DEPTH    = 4;
	localparam int RES_PTR_BITS = 2;
	localparam int RES_CNT_BITS = 3;

	// One result record
	typedef struct packed {
		logic is_local_max;
		logic end_of_frame;
		logic last;
	} result_t;

endpackage

// ===== rtl/lmcd_pixel_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcd_pixel_if
// Valid/ready channel that carries one signed pixel per request.
// ----------------------------------------------------------------------------
interface lmcd_pixel_if #(
	parameter int PIXEL_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [PIXEL_BITS-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

// ===== rtl/lmcd_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcd_result_if
// Valid/ready channel that carries one detection result per request.
// ----------------------------------------------------------------------------
interface lmcd_result_if;
	logic valid;
	logic ready;
	logic is_local_max;
	logic end_of_frame;
	logic last;

	modport source (output valid, output is_local_max, output end_of_frame,
		output last, input ready);
	modport sink   (input valid, input is_local_max, input end_of_frame,
		input last, output ready);
endinterface

// ===== rtl/local_max_cross_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_max_cross_detector
// 4-neighbour local maximum detector over a raster-scanned frame.
//
// Pixels enter on the pixels channel in raster order, one per request. The
// flag of a pixel leaves on the results channel when the pixel below it
// arrives; border pixels are always flagged 0. Pixels of the first row give
// no result, middle rows give one, and each pixel of the last row gives two
// (the flag of the pixel above, then its own 0 flag carrying end_of_frame in
// the final column). last marks the final result of each request.
// The user must write frame_width and frame_height on the cfg port only
// while idle; the block does not enforce this. They are clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT. Throughput: one pixel per cycle in all
// rows but the last while results are taken; in the last row the single
// result port drains two results per pixel, so pixels are held back there.
// A line memory with two registered read ports feeds the compare.
// Results wait in a four-entry queue; pixels are taken while it holds two
// or fewer, so a stalled receiver backs up the pixel side after that.
// Reset clears counters, queue and registers to width and height 5; the
// line memory is not cleared.
// ----------------------------------------------------------------------------
module local_max_cross_detector #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	lmcd_pixel_if.sink                          pixels,
	lmcd_result_if.source                       results,
	input  logic                                cfg_we,
	input  logic [lmcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [lmcd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WB  = $clog2(MAX_WIDTH + 1);
	localparam int HB  = $clog2(MAX_HEIGHT + 1);
	localparam int CB0 = (WB > HB) ? WB : HB;
	localparam int CB  = (CB0 > lmcd_pkg::CFG_DATA_BITS) ? CB0 : lmcd_pkg::CFG_DATA_BITS;
	localparam int EB  = 2 * PIXEL_BITS;

	// Clamp a written frame side into DIM_MIN..maxv
	function automatic logic [CB-1:0] clamp_dim(
		input logic [lmcd_pkg::CFG_DATA_BITS-1:0] v,
		input logic [CB-1:0]                     maxv
	);
		logic [CB-1:0] ve;
		ve = CB'(v);
		if (ve < CB'(lmcd_pkg::DIM_MIN))
			return CB'(lmcd_pkg::DIM_MIN);
		else if (ve > maxv)
			return maxv;
		else
			return ve;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers, held already clamped
	// ------------------------------------------------------------------
	logic [WB-1:0] width_q, width_d;
	logic [HB-1:0] height_q;
	logic          wr_width, wr_height;

	assign wr_width  = cfg_we && (cfg_index == lmcd_pkg::CFG_FRAME_WIDTH);
	assign wr_height = cfg_we && (cfg_index == lmcd_pkg::CFG_FRAME_HEIGHT);
	assign width_d   = wr_width ? WB'(clamp_dim(cfg_data, CB'(MAX_WIDTH))) : width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WB'(clamp_dim(lmcd_pkg::FRAME_WIDTH_RESET, CB'(MAX_WIDTH)));
			height_q <= HB'(clamp_dim(lmcd_pkg::FRAME_HEIGHT_RESET, CB'(MAX_HEIGHT)));
		end else begin
			width_q <= width_d;
			if (wr_height)
				height_q <= HB'(clamp_dim(cfg_data, CB'(MAX_HEIGHT)));
		end
	end

	// ------------------------------------------------------------------
	// Position of the incoming pixel
	// ------------------------------------------------------------------
	logic [CW-1:0] col_q, col_eff, col_next, col_d;
	logic [RW-1:0] row_q, row_eff, row_next;
	logic [WB-1:0] w_m1, wd_m1;
	logic [HB-1:0] h_m1;
	logic          last_col, last_row;
	logic          accept;

	assign w_m1     = width_q - WB'(1);
	assign h_m1     = height_q - HB'(1);
	assign col_eff  = (WB'(col_q) >= w_m1) ? CW'(w_m1) : col_q;
	assign row_eff  = (HB'(row_q) >= h_m1) ? RW'(h_m1) : row_q;
	assign last_col = (WB'(col_eff) == w_m1);
	assign last_row = (HB'(row_eff) == h_m1);
	assign col_next = last_col ? '0 : col_eff + CW'(1);
	assign row_next = !last_col ? row_eff : (last_row ? '0 : row_eff + RW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	// ------------------------------------------------------------------
	// Line memory: each entry holds {row above, row two above} of a column.
	// The read ports look ahead at the next pixel's column and the one
	// to its right, so the data is ready when that pixel arrives.
	// ------------------------------------------------------------------
	logic [EB-1:0] line_mem [MAX_WIDTH];
	logic [EB-1:0] rd_a_q, rd_b_q;
	logic [CW-1:0] addr_a, addr_b;
	logic signed [PIXEL_BITS-1:0] px, centre, up, right, left_q;

	assign col_d  = accept ? col_next : col_q;
	assign wd_m1  = width_d - WB'(1);
	assign addr_a = (WB'(col_d) >= wd_m1) ? CW'(wd_m1) : col_d;
	assign addr_b = (WB'(addr_a) == wd_m1) ? '0 : addr_a + CW'(1);

	assign px     = pixels.pixel;
	assign centre = rd_a_q[EB-1:PIXEL_BITS];
	assign up     = rd_a_q[PIXEL_BITS-1:0];
	assign right  = rd_b_q[EB-1:PIXEL_BITS];

	always_ff @(posedge clk) begin
		if (accept)
			line_mem[col_eff] <= {px, centre};
		rd_a_q <= line_mem[addr_a];
		rd_b_q <= line_mem[addr_b];
	end

	// Left neighbour is the centre seen by the previous pixel
	always_ff @(posedge clk) begin
		if (accept)
			left_q <= centre;
	end

	// ------------------------------------------------------------------
	// Compare and build the results of this pixel
	// ------------------------------------------------------------------
	logic              interior, flag;
	logic [1:0]        push_n;
	lmcd_pkg::result_t res0, res1;

	assign interior = (row_eff >= RW'(2)) && (col_eff != '0) && !last_col;
	assign flag     = interior && (centre >= up) && (centre >= left_q)
		&& (centre >= right) && (centre >= px);

	always_comb begin
		res0.is_local_max = flag;
		res0.end_of_frame = 1'b0;
		res0.last         = !last_row;
		res1.is_local_max = 1'b0;
		res1.end_of_frame = last_col;
		res1.last         = 1'b1;
		if (row_eff == '0)
			push_n = 2'd0;
		else if (last_row)
			push_n = 2'd2;
		else
			push_n = 2'd1;
	end

	// ------------------------------------------------------------------
	// Result queue
	// ------------------------------------------------------------------
	lmcd_pkg::result_t                   res_q [lmcd_pkg::RES_DEPTH];
	logic [lmcd_pkg::RES_PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [lmcd_pkg::RES_CNT_BITS-1:0]   cnt_q;
	logic [lmcd_pkg::RES_CNT_BITS-1:0]   push_cnt;
	logic                                pop;

	assign pixels.ready = (cnt_q <= lmcd_pkg::RES_CNT_BITS'(lmcd_pkg::RES_DEPTH - 2));
	assign accept       = pixels.valid && pixels.ready;
	assign pop          = results.valid && results.ready;
	assign push_cnt     = accept ? lmcd_pkg::RES_CNT_BITS'(push_n) : '0;

	always_ff @(posedge clk) begin
		if (accept && (push_n != 2'd0))
			res_q[wr_ptr_q] <= res0;
		if (accept && (push_n == 2'd2))
			res_q[wr_ptr_q + lmcd_pkg::RES_PTR_BITS'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + lmcd_pkg::RES_PTR_BITS'(push_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + lmcd_pkg::RES_PTR_BITS'(1);
			cnt_q <= cnt_q + push_cnt - lmcd_pkg::RES_CNT_BITS'(pop);
		end
	end

	assign results.valid        = (cnt_q != '0);
	assign results.is_local_max = res_q[rd_ptr_q].is_local_max;
	assign results.end_of_frame = res_q[rd_ptr_q].end_of_frame;
	assign results.last         = res_q[rd_ptr_q].last;

endmodule

// ===== test/local_max_cross_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_max_cross_detector_tb
// Drives raster-order pixel frames into the cross-shaped local maximum
// detector and checks every flag against an in-bench line-store predictor.
// Covers a hand-built frame at reset size, clamped and extreme frame sizes,
// a resize in the middle of a frame, and random frames with random gaps on
// both channels plus one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module local_max_cross_detector_tb;

	localparam int MAX_SIDE       = 1024;
	localparam int MAX_GAP        = 12;
	localparam int STALL_LIMIT    = 5000;
	localparam int HOLD_OFF_LEN   = 400;
	localparam int RANDOM_PIXELS  = 280;
	localparam int MAX_REPORTS    = 10;

	typedef enum logic [1:0] {
		SPREAD_FULL,
		SPREAD_NARROW,
		SPREAD_EXTREME
	} spread_t;

	typedef logic [lmcd_pkg::CFG_DATA_BITS-1:0] cfg_word_t;

	logic                                          clk = 1'b0;
	logic                                          arst_n;
	logic                                          cfg_we;
	logic [lmcd_pkg::CFG_INDEX_BITS-1:0]           cfg_index;
	logic [lmcd_pkg::CFG_DATA_BITS-1:0]            cfg_data;

	lmcd_pixel_if #(.PIXEL_BITS(16)) pix_ch ();
	lmcd_result_if                   res_ch ();

	local_max_cross_detector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix_ch),
		.results   (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: register copies, line stores, raster position
	logic [lmcd_pkg::CFG_DATA_BITS-1:0] model_width;
	logic [lmcd_pkg::CFG_DATA_BITS-1:0] model_height;
	logic signed [15:0]       line_above     [MAX_SIDE];
	logic signed [15:0]       line_two_above [MAX_SIDE];
	int                       row_pos;
	int                       col_pos;

	lmcd_pkg::result_t flags_due [$];
	int      mismatch_count = 0;
	int      pixels_sent    = 0;
	int      stall_cycles   = 0;
	int      hold_off_cycles = 0;
	bit      src_idle_en;
	bit      sink_idle_en;

	always #5 clk = ~clk;

	function automatic int dim_used(input logic [lmcd_pkg::CFG_DATA_BITS-1:0] v);
		if (v < lmcd_pkg::DIM_MIN)
			return lmcd_pkg::DIM_MIN;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return int'(v);
	endfunction

	function automatic logic signed [15:0] draw_pixel(input spread_t spread);
		case (spread)
			SPREAD_NARROW: begin
				return 16'($signed($urandom_range(0, 6)) - 3);
			end
			SPREAD_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	// Flags due for one accepted pixel; updates line stores and position
	task automatic predict_cross_max(input logic signed [15:0] px);
		int      w;
		int      h;
		int      c;
		int      r;
		lmcd_pkg::result_t due;
		w = dim_used(model_width);
		h = dim_used(model_height);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		if (r >= 1) begin
			due.is_local_max = 1'b0;
			// pixel reported here sits one row up, same column
			if (r >= 2 && c >= 1 && c + 1 < w) begin
				due.is_local_max = line_above[c] >= line_two_above[c] &&
					line_above[c] >= line_two_above[c - 1] &&
					line_above[c] >= line_above[c + 1] &&
					line_above[c] >= px;
			end
			due.end_of_frame = 1'b0;
			due.last         = (r != h - 1);
			flags_due.push_back(due);
			// last row also reports its own border flag
			if (r == h - 1) begin
				due = '{1'b0, (c == w - 1), 1'b1};
				flags_due.push_back(due);
			end
		end
		line_two_above[c] = line_above[c];
		line_above[c]     = px;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// Offer one pixel after a random gap, if enabled, and wait for the request to go through
	task automatic send_pixel(input logic signed [15:0] px);
		int gap;
		gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= px;
		do @(posedge clk); while (!pix_ch.ready);
		pixels_sent++;
		predict_cross_max(px);
	endtask

	// Send until the raster position is back at the top-left corner
	task automatic send_rest_of_frame(input spread_t spread);
		do send_pixel(draw_pixel(spread)); while (row_pos != 0 || col_pos != 0);
	endtask

	// Stop offering, let every due flag arrive, then allow the pipe to settle
	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		while (flags_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers are written back to back, only while idle
	task automatic set_frame_size(input logic [lmcd_pkg::CFG_DATA_BITS-1:0] w,
		input logic [lmcd_pkg::CFG_DATA_BITS-1:0] h);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= lmcd_pkg::CFG_FRAME_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= lmcd_pkg::CFG_FRAME_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we       <= 1'b0;
		model_width  = w;
		model_height = h;
	endtask

	task automatic report_flag_error(input string what, input lmcd_pkg::result_t want,
		input lmcd_pkg::result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s: expected max=%b eof=%b last=%b, got max=%b eof=%b last=%b",
				$realtime, what, want.is_local_max, want.end_of_frame, want.last,
				got.is_local_max, got.end_of_frame, got.last);
	endtask

	// Hand-built 5x5 frame at the reset size: extremes, ties, near misses
	task automatic test_reset_frame();
		int pattern [25] = '{
			-32768,      0,      5,      0,  32767,
			     0,  32767,      7,      7, -32768,
			     3,     -1,      7,     -2,      0,
			-32768,     -5, -32768,     -5,      1,
			 32767,     -6,     -5,      1, -32768
		};
		foreach (pattern[i])
			send_pixel(16'(pattern[i]));
	endtask

	// Register values below the minimum are used as 3
	task automatic test_clamped_sizes();
		set_frame_size(11'd0, 11'd1);
		send_rest_of_frame(SPREAD_EXTREME);
		set_frame_size(11'd2, 11'd0);
		send_rest_of_frame(SPREAD_NARROW);
		set_frame_size(11'd1, 11'd2);
		send_rest_of_frame(SPREAD_FULL);
	endtask

	// Narrow the frame and cut its height while inside row 4, column 5
	task automatic test_midframe_resize();
		set_frame_size(11'd6, 11'd6);
		repeat (29)
			send_pixel(draw_pixel(SPREAD_NARROW));
		set_frame_size(11'd4, 11'd3);
		send_rest_of_frame(SPREAD_NARROW);
		send_rest_of_frame(SPREAD_NARROW);
	endtask

	// Widest and tallest frames, reached through out-of-range values too;
	// each is cut down to a small size part way in to keep the run short
	task automatic test_extreme_sizes();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b1;
		set_frame_size(11'd2047, 11'd3);
		repeat (40)
			send_pixel(draw_pixel(SPREAD_NARROW));
		set_frame_size(11'd3, 11'd3);
		send_rest_of_frame(SPREAD_NARROW);
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b0;
		set_frame_size(11'd3, 11'd1025);
		repeat (30)
			send_pixel(draw_pixel(SPREAD_FULL));
		set_frame_size(11'd3, 11'd3);
		send_rest_of_frame(SPREAD_FULL);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		set_frame_size(11'd1024, 11'd3);
		repeat (40)
			send_pixel(draw_pixel(SPREAD_EXTREME));
		set_frame_size(11'd5, 11'd3);
		send_rest_of_frame(SPREAD_EXTREME);
	endtask

	// Random small frames; the first one runs into a long receiver hold-off
	task automatic test_random_frames();
		int      first;
		int      frame_idx;
		logic [lmcd_pkg::CFG_DATA_BITS-1:0] w;
		logic [lmcd_pkg::CFG_DATA_BITS-1:0] h;
		spread_t spread;
		first     = pixels_sent;
		frame_idx = 0;
		while (pixels_sent - first < RANDOM_PIXELS) begin
			case ($urandom_range(0, 9))
				0: w = cfg_word_t'($urandom_range(0, 2));
				1: w = cfg_word_t'($urandom_range(13, 40));
				default: w = cfg_word_t'($urandom_range(3, 12));
			endcase
			case ($urandom_range(0, 9))
				0: h = cfg_word_t'($urandom_range(0, 2));
				1: h = cfg_word_t'($urandom_range(9, 16));
				default: h = cfg_word_t'($urandom_range(3, 8));
			endcase
			case ($urandom_range(0, 5))
				0: spread = SPREAD_EXTREME;
				1, 2: spread = SPREAD_FULL;
				default: spread = SPREAD_NARROW;
			endcase
			src_idle_en  = ($urandom_range(0, 3) != 0);
			sink_idle_en = ($urandom_range(0, 3) != 0);
			set_frame_size(w, h);
			if (frame_idx == 0) begin
				src_idle_en     = 1'b0;
				hold_off_cycles = HOLD_OFF_LEN;
			end
			send_rest_of_frame(spread);
			frame_idx++;
		end
	endtask

	// Result side: random ready gaps, optional hold-off, in-order compare
	initial begin
		int      gap;
		lmcd_pkg::result_t got;
		lmcd_pkg::result_t want;
		res_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_off_cycles > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			gap = sink_idle_en ? $urandom_range(0, MAX_GAP) : 0;
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			got = '{res_ch.is_local_max, res_ch.end_of_frame, res_ch.last};
			if (flags_due.size() == 0) begin
				report_flag_error("unexpected result", '{1'b0, 1'b0, 1'b0}, got);
			end else begin
				want = flags_due.pop_front();
				if (got.is_local_max !== want.is_local_max ||
					got.end_of_frame !== want.end_of_frame ||
					got.last !== want.last)
					report_flag_error("flag mismatch", want, got);
			end
		end
	end

	// Watchdog: too long with no request on either channel
	always @(posedge clk) begin
		if (!arst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("local_max_cross_detector_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		cfg_we       = 1'b0;
		cfg_index    = lmcd_pkg::CFG_FRAME_WIDTH;
		cfg_data     = '0;
		model_width  = lmcd_pkg::FRAME_WIDTH_RESET;
		model_height = lmcd_pkg::FRAME_HEIGHT_RESET;
		row_pos      = 0;
		col_pos      = 0;
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_frame();
		test_clamped_sizes();
		test_midframe_resize();
		test_extreme_sizes();
		test_random_frames();

		wait_drained();
		if (mismatch_count == 0 && flags_due.size() == 0)
			$display("local_max_cross_detector_tb OK");
		else
			$display("local_max_cross_detector_tb NOT OK");
		$finish;
	end

endmodule
